// ===== design/rbtz_pkg.sv =====
// shared types, constants and helper functions for the rtc time zone adjust block
package rbtz_pkg;

  localparam logic signed [5:0] ZONE_RESET = -6'sd3;
  localparam logic signed [5:0] ZONE_MIN   = -6'sd23;
  localparam logic signed [5:0] ZONE_MAX   = 6'sd23;
  localparam logic [11:0]       YEAR_BASE  = 12'd2000;
  localparam logic [7:0]        HOURS_DAY  = 8'd24;
  localparam logic [7:0]        SEC_MAX    = 8'd59;
  localparam logic [7:0]        HOUR_MAX   = 8'd23;
  localparam logic [7:0]        MONTHS     = 8'd12;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yv;
    logic       ok;
  } rbtz_decoded_t;

  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hr;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [11:0] year;
    logic        invalid;
  } rbtz_result_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0000, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
  endfunction

  function automatic logic bcd_ok(input logic [7:0] b);
    return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  // month must lie in 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== design/rbtz_decode.sv =====
// bcd decode and calendar range check of one clock snapshot
module rbtz_decode
  import rbtz_pkg::*;
(
  input  logic [7:0]    bcd_seconds,
  input  logic [7:0]    bcd_minutes,
  input  logic [7:0]    bcd_hours,
  input  logic [7:0]    bcd_day,
  input  logic [7:0]    bcd_month,
  input  logic [7:0]    bcd_year,
  output rbtz_decoded_t dec
);

  logic       digits_ok;
  logic       leap;
  logic [4:0] len;

  always_comb begin
    dec.sec = bcd_value(bcd_seconds);
    dec.min = bcd_value(bcd_minutes);
    dec.hr  = bcd_value(bcd_hours);
    dec.day = bcd_value(bcd_day);
    dec.mon = bcd_value(bcd_month);
    dec.yv  = bcd_value(bcd_year);

    digits_ok = bcd_ok(bcd_seconds) && bcd_ok(bcd_minutes) && bcd_ok(bcd_hours) &&
                bcd_ok(bcd_day) && bcd_ok(bcd_month) && bcd_ok(bcd_year);
    // valid years are 2000..2099, where every fourth year is leap
    leap = (dec.yv[1:0] == 2'b00);
    len  = month_days(dec.mon[3:0], leap);

    dec.ok = digits_ok;
    if (dec.sec > SEC_MAX || dec.min > SEC_MAX || dec.hr > HOUR_MAX) begin
      dec.ok = 1'b0;
    end
    if (dec.mon < 8'd1 || dec.mon > MONTHS) begin
      dec.ok = 1'b0;
    end else if (dec.day < 8'd1 || dec.day > {3'b000, len}) begin
      dec.ok = 1'b0;
    end
  end

endmodule

// ===== design/rbtz_adjust.sv =====
// zone offset, hour wrap and day, month, year rollover
module rbtz_adjust
  import rbtz_pkg::*;
(
  input  rbtz_decoded_t     dec,
  input  logic signed [5:0] zone,
  output rbtz_result_t      res
);

  logic signed [5:0] off;
  logic [7:0]        h_sum;
  logic [7:0]        day_adj;
  logic [11:0]       year;
  logic              leap;
  logic [4:0]        cur_len;
  logic [3:0]        prev_mon;
  logic [11:0]       prev_year;
  logic [4:0]        prev_len;

  always_comb begin
    if (zone < ZONE_MIN) begin
      off = ZONE_MIN;
    end else if (zone > ZONE_MAX) begin
      off = ZONE_MAX;
    end else begin
      off = zone;
    end

    year  = YEAR_BASE + {4'b0000, dec.yv};
    leap  = (dec.yv[1:0] == 2'b00);
    h_sum = {3'b000, dec.hr[4:0]} + {{2{off[5]}}, off};

    res.sec     = dec.sec;
    res.min     = dec.min;
    res.hr      = dec.hr;
    res.day     = dec.day;
    res.mon     = dec.mon;
    res.year    = year;
    res.invalid = ~dec.ok;

    day_adj = dec.day;
    if ($signed(h_sum) >= $signed(HOURS_DAY)) begin
      day_adj = dec.day + 8'd1;
      h_sum   = h_sum - HOURS_DAY;
    end else if (h_sum[7]) begin
      day_adj = dec.day - 8'd1;
      h_sum   = h_sum + HOURS_DAY;
    end

    cur_len = month_days(dec.mon[3:0], leap);
    if (dec.mon[3:0] == 4'd1) begin
      prev_mon  = 4'd12;
      prev_year = year - 12'd1;
    end else begin
      prev_mon  = dec.mon[3:0] - 4'd1;
      prev_year = year;
    end
    prev_len = month_days(prev_mon, leap);

    if (dec.ok) begin
      res.hr = h_sum;
      if (day_adj > {3'b000, cur_len}) begin
        res.day = 8'd1;
        if (dec.mon == MONTHS) begin
          res.mon  = 8'd1;
          res.year = year + 12'd1;
        end else begin
          res.mon = dec.mon + 8'd1;
        end
      end else if (day_adj == 8'd0) begin
        res.day  = {3'b000, prev_len};
        res.mon  = {4'b0000, prev_mon};
        res.year = prev_year;
      end else begin
        res.day = day_adj;
      end
    end
  end

endmodule

// ===== design/rtc_bcd_time_zone_adjust.sv =====
// top level: rtc bcd snapshot to local date and time with zone offset
// Each transfer carries six raw BCD clock bytes; the result holds the decoded
// seconds and minutes, the local hour after the signed zone offset, and the
// local day, month and full year after Gregorian rollover. An invalid snapshot
// passes through decoded but unadjusted with date_invalid set. The block is an
// input register, one pass of decode and adjust logic, and a result register:
// one item per cycle sustained while out_stall is low. The zone offset
// (reset -3, clamped to -23..23) is written through cfg_we and cfg_data; the
// user must do so only while no item is in flight; the block does not enforce it.
module rtc_bcd_time_zone_adjust
  import rbtz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic signed [5:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        bcd_seconds,
  input  logic [7:0]        bcd_minutes,
  input  logic [7:0]        bcd_hours,
  input  logic [7:0]        bcd_day,
  input  logic [7:0]        bcd_month,
  input  logic [7:0]        bcd_year,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_seconds,
  output logic [7:0]        out_minutes,
  output logic [7:0]        out_hours,
  output logic [7:0]        out_day,
  output logic [7:0]        out_month,
  output logic [11:0]       out_year,
  output logic              date_invalid
);

  logic signed [5:0] zone;
  logic              s1_valid;
  logic [7:0]        s1_sec;
  logic [7:0]        s1_min;
  logic [7:0]        s1_hr;
  logic [7:0]        s1_day;
  logic [7:0]        s1_mon;
  logic [7:0]        s1_yr;
  logic              out_load;
  logic              s1_load;
  rbtz_decoded_t     dec;
  rbtz_result_t      res;
  rbtz_result_t      out_reg;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ZONE_RESET;
    end else if (cfg_we) begin
      zone <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sec <= bcd_seconds;
      s1_min <= bcd_minutes;
      s1_hr  <= bcd_hours;
      s1_day <= bcd_day;
      s1_mon <= bcd_month;
      s1_yr  <= bcd_year;
    end
  end

  rbtz_decode u_decode (
    .bcd_seconds (s1_sec),
    .bcd_minutes (s1_min),
    .bcd_hours   (s1_hr),
    .bcd_day     (s1_day),
    .bcd_month   (s1_mon),
    .bcd_year    (s1_yr),
    .dec         (dec)
  );

  rbtz_adjust u_adjust (
    .dec  (dec),
    .zone (zone),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res;
    end
  end

  assign out_seconds  = out_reg.sec;
  assign out_minutes  = out_reg.min;
  assign out_hours    = out_reg.hr;
  assign out_day      = out_reg.day;
  assign out_month    = out_reg.mon;
  assign out_year     = out_reg.year;
  assign date_invalid = out_reg.invalid;

endmodule

// ===== tb/rtc_bcd_time_zone_adjust_test.sv =====
// self-checking testbench for the rtc bcd snapshot to local time block
module rtc_bcd_time_zone_adjust_test;
  import rbtz_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yr;
  } snapshot_t;

  typedef struct packed {
    snapshot_t    snap;
    logic         fixed;
    rbtz_result_t want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic signed [5:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        bcd_seconds;
  logic [7:0]        bcd_minutes;
  logic [7:0]        bcd_hours;
  logic [7:0]        bcd_day;
  logic [7:0]        bcd_month;
  logic [7:0]        bcd_year;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_seconds;
  logic [7:0]        out_minutes;
  logic [7:0]        out_hours;
  logic [7:0]        out_day;
  logic [7:0]        out_month;
  logic [11:0]       out_year;
  logic              date_invalid;

  logic signed [5:0] zone_now;
  rbtz_result_t      pending_times[$];
  stim_row_t         directed_rows[$];
  int                zone_plan[$];
  int                mismatch_count = 0;
  int                checked_count = 0;
  int                invalid_count = 0;
  int                stall_count = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;
  bit                hold_request = 1'b0;

  rtc_bcd_time_zone_adjust u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .bcd_seconds  (bcd_seconds),
    .bcd_minutes  (bcd_minutes),
    .bcd_hours    (bcd_hours),
    .bcd_day      (bcd_day),
    .bcd_month    (bcd_month),
    .bcd_year     (bcd_year),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_seconds  (out_seconds),
    .out_minutes  (out_minutes),
    .out_hours    (out_hours),
    .out_day      (out_day),
    .out_month    (out_month),
    .out_year     (out_year),
    .date_invalid (date_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int month_length(input int m, input int y);
    bit leap_year;
    leap_year = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    case (m)
      2: return leap_year ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic logic [7:0] to_bcd(input int n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  function automatic rbtz_result_t local_time(input snapshot_t s,
                                              input logic signed [5:0] zone);
    logic [7:0]   raw [6];
    int           v [6];
    bit           good;
    int           off;
    int           h;
    int           d;
    int           m;
    int           y;
    rbtz_result_t r;
    raw = '{s.sec, s.min, s.hr, s.day, s.mon, s.yr};
    good = 1'b1;
    for (int i = 0; i < 6; i++) begin
      v[i] = int'(raw[i][7:4]) * 10 + int'(raw[i][3:0]);
      if (raw[i][7:4] > 4'd9 || raw[i][3:0] > 4'd9) good = 1'b0;
    end
    h = v[2];
    d = v[3];
    m = v[4];
    y = int'(YEAR_BASE) + v[5];
    if (v[0] > 59 || v[1] > 59 || h > 23) good = 1'b0;
    if (m < 1 || m > 12) good = 1'b0;
    else if (d < 1 || d > month_length(m, y)) good = 1'b0;
    if (good) begin
      off = zone;
      if (off < int'(ZONE_MIN)) off = int'(ZONE_MIN);
      if (off > int'(ZONE_MAX)) off = int'(ZONE_MAX);
      h = h + off;
      if (h >= 24) begin
        h = h - 24;
        d++;
      end else if (h < 0) begin
        h = h + 24;
        d--;
      end
      if (d > month_length(m, y)) begin
        d = 1;
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end else if (d == 0) begin
        m--;
        if (m == 0) begin
          m = 12;
          y--;
        end
        d = month_length(m, y);
      end
    end
    r.sec = 8'(v[0]);
    r.min = 8'(v[1]);
    r.hr = 8'(h);
    r.day = 8'(d);
    r.mon = 8'(m);
    r.year = 12'(y);
    r.invalid = !good;
    return r;
  endfunction

  // mostly well-formed dates with edge-heavy days and hours, the rest broken
  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    int        pick;
    int        y;
    int        m;
    int        d;
    int        h;
    int        last;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0: y = 0;
      1: y = 99;
      default: y = $urandom_range(0, 99);
    endcase
    m = $urandom_range(1, 12);
    last = month_length(m, int'(YEAR_BASE) + y);
    case ($urandom_range(0, 3))
      0: d = 1;
      1: d = last;
      default: d = $urandom_range(1, last);
    endcase
    case ($urandom_range(0, 3))
      0: h = 0;
      1: h = 23;
      default: h = $urandom_range(0, 23);
    endcase
    s = {to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)), to_bcd(h),
         to_bcd(d), to_bcd(m), to_bcd(y)};
    if (pick < 10) s = {$urandom(), 16'($urandom())};
    else if (pick < 18) s.day = to_bcd(last + 1);
    else if (pick < 28) s[8 * $urandom_range(0, 5) +: 8] = 8'($urandom());
    return s;
  endfunction

  task automatic add_row(input snapshot_t s, input logic fixed, input rbtz_result_t want);
    stim_row_t row;
    row.snap = s;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_snapshot(input snapshot_t s, input logic fixed,
                               input rbtz_result_t want);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {bcd_seconds, bcd_minutes, bcd_hours, bcd_day, bcd_month, bcd_year} <= s;
    @(negedge clk);
    while (in_stall) begin
      stall_count++;
      @(negedge clk);
    end
    @(posedge clk);
    if (fixed) pending_times.push_back(want);
    else pending_times.push_back(local_time(s, zone_now));
    if (pending_times[$].invalid) invalid_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_zone(input logic signed [5:0] zone);
    cfg_we <= 1'b1;
    cfg_data <= zone;
    @(posedge clk);
    zone_now = zone;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver side stall bursts and the long hold-off
  initial begin : receiver
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        burst = 0;
        while (burst < HOLD_CYCLES) begin
          @(posedge clk);
          burst++;
        end
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result transfer happens at the next rising edge
  always @(negedge clk) begin : monitor
    rbtz_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_times.size() == 0) begin
        $error("result with no snapshot pending");
        mismatch_count++;
      end else begin
        want = pending_times.pop_front();
        checked_count++;
        check_field("out_seconds", want.sec, out_seconds);
        check_field("out_minutes", want.min, out_minutes);
        check_field("out_hours", want.hr, out_hours);
        check_field("out_day", want.day, out_day);
        check_field("out_month", want.mon, out_month);
        check_field("out_year", want.year, out_year);
        check_field("date_invalid", want.invalid, date_invalid);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 6'sd0;
    in_valid = 1'b0;
    {bcd_seconds, bcd_minutes, bcd_hours, bcd_day, bcd_month, bcd_year} = 48'd0;
    zone_now = ZONE_RESET;

    add_row({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
            '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd2000, 1'b1});
    add_row({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
            '{8'd165, 8'd165, 8'd165, 8'd165, 8'd165, 12'd2165, 1'b1});
    add_row({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}, 1'b1,
            '{8'd59, 8'd59, 8'd20, 8'd31, 8'd12, 12'd2099, 1'b0});
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1,
            '{8'd0, 8'd0, 8'd21, 8'd31, 8'd12, 12'd1999, 1'b0});
    // back across a leap day, a plain february and a century leap year
    add_row({8'h00, 8'h00, 8'h02, 8'h01, 8'h03, 8'h04}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'h01}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00}, 1'b0, '0);
    add_row({8'h30, 8'h15, 8'h03, 8'h29, 8'h02, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h05, 8'h20}, 1'b0, '0);
    add_row({8'h45, 8'h07, 8'h12, 8'h15, 8'h06, 8'h37}, 1'b0, '0);
    // invalid snapshots: bad nibbles and out-of-range fields
    add_row({8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h01}, 1'b0, '0);
    add_row({8'h0a, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'ha0, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h0f, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h1f, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h1a, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9a}, 1'b0, '0);
    add_row({8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h00}, 1'b0, '0);
    add_row({8'h00, 8'h00, 8'h05, 8'h00, 8'h05, 8'h10}, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_snapshot(directed_rows[i].snap, directed_rows[i].fixed, directed_rows[i].want);
    wait_idle();

    // limits, raw values beyond the clamp, a few ordinary zones, quiet last phase
    zone_plan = '{-23, 23, 0, 31, -32, 12, -1};
    zone_plan.push_back($urandom_range(0, 63) - 32);
    zone_plan.push_back($urandom_range(0, 63) - 32);
    zone_plan.push_back(5);
    for (int p = 0; p < zone_plan.size(); p++) begin
      set_zone(6'(zone_plan[p]));
      if (p == 1) hold_request = 1'b1;
      calm = (p == zone_plan.size() - 1);
      repeat (PHASE_ITEMS) send_snapshot(random_snapshot(), 1'b0, '0);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (pending_times.size() != 0) begin
      $error("%0d results never arrived", pending_times.size());
      mismatch_count++;
    end
    $display("checked %0d local times over %0d zone settings, %0d invalid snapshots",
             checked_count, zone_plan.size() + 1, invalid_count);
    $display("input stalled on %0d cycles, %0d mismatches", stall_count, mismatch_count);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
